// ===== rtl/wltc_pkg.sv =====
// shared types and codes for the window limit trip checker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package wltc_pkg;

  localparam int unsigned CHANNELS     = 16;
  localparam int unsigned CHAN_W       = 4;
  localparam int unsigned CHAN_AW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned READING_BITS = 16;
  localparam int unsigned COUNT_W      = 16;

  localparam logic [1:0] SIDE_MASKED  = 2'd0;
  localparam logic [1:0] SIDE_ARMED   = 2'd1;
  localparam logic [1:0] SIDE_TRIPPED = 2'd2;
  localparam logic [1:0] SIDE_FREE    = 2'd3;

  localparam logic [1:0] REP_CLEAR = 2'd0;
  localparam logic [1:0] REP_UNDER = 2'd1;
  localparam logic [1:0] REP_OVER  = 2'd2;

  localparam logic OP_CHECK = 1'b0;
  localparam logic OP_SETUP = 1'b1;

  typedef struct packed {
    logic [1:0]              high_mode;
    logic [1:0]              low_mode;
    logic [READING_BITS-1:0] over_limit;
    logic [READING_BITS-1:0] under_limit;
    logic [COUNT_W-1:0]      event_count;
  } wltc_entry_t;

  localparam int unsigned ENTRY_W = $bits(wltc_entry_t);

endpackage

`default_nettype wire

// ===== rtl/wltc_ram.sv =====
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module wltc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/window_limit_trip_checker.sv =====
// top level of the per-channel window limit trip checker
// uses wltc_pkg and wltc_ram
`timescale 1ns / 1ps
`default_nettype none

// The accept edge reads the channel's entry from the state ram; once the
// output register is free or draining, the finish edge updates the entry,
// writes it back and loads the result register. No new item is taken during
// that read-modify-write of the single state ram, but one is taken while the
// previous result still waits in the output register. Per-channel valid bits
// make never-written entries read as zero after reset, so no clearing pass is
// needed. Every item, check or setup, yields exactly one result.
module window_limit_trip_checker
  import wltc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic        mode_i,
  input  wire logic [3:0]  channel_i,
  input  wire logic [15:0] reading_i,
  input  wire logic [15:0] high_limit_i,
  input  wire logic [15:0] low_limit_i,
  input  wire logic        high_enable_i,
  input  wire logic        low_enable_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [3:0]       out_channel_o,
  output logic             report_valid_o,
  output logic [1:0]       report_code_o,
  output logic [1:0]       high_state_o,
  output logic [1:0]       low_state_o,
  output logic [15:0]      event_total_o
);

  logic busy_q, busy_d;
  logic out_valid_q, out_valid_d;
  logic [CHANNELS-1:0] written_q, written_d;

  logic                    op_q;
  logic [CHAN_W-1:0]       chan_q;
  logic [READING_BITS-1:0] reading_q, high_limit_q, low_limit_q;
  logic                    high_en_q, low_en_q;

  logic        accept, finish, in_range;
  logic [CHAN_AW-1:0] raddr, waddr;
  wltc_entry_t rdata, cur, nxt;

  logic              rep_valid_d, rep_valid_q;
  logic [1:0]        rep_code_d, rep_code_q;
  logic [1:0]        hs_q, ls_q;
  logic [COUNT_W-1:0] total_q;
  logic [CHAN_W-1:0] ochan_q;
  logic              over, under;

  assign in_ready_o = !busy_q;
  assign accept     = in_valid_i && in_ready_o;
  assign finish     = busy_q && (!out_valid_q || out_ready_i);
  assign raddr      = channel_i[CHAN_AW-1:0];
  assign waddr      = chan_q[CHAN_AW-1:0];
  assign in_range   = ({1'b0, chan_q} < (CHAN_W + 1)'(CHANNELS));

  wltc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CHANNELS)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (finish && in_range),
    .waddr_i (waddr),
    .wdata_i (nxt),
    .re_i    (accept),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q         <= mode_i;
      chan_q       <= channel_i;
      reading_q    <= reading_i[READING_BITS-1:0];
      high_limit_q <= high_limit_i[READING_BITS-1:0];
      low_limit_q  <= low_limit_i[READING_BITS-1:0];
      high_en_q    <= high_enable_i;
      low_en_q     <= low_enable_i;
    end
  end

  // never-written entries read as reset state
  assign cur   = written_q[waddr] ? rdata : '0;
  assign over  = (cur.high_mode != SIDE_MASKED) && (reading_q > cur.over_limit);
  assign under = (cur.low_mode != SIDE_MASKED) && (reading_q < cur.under_limit);

  always_comb begin
    nxt         = cur;
    rep_valid_d = 1'b0;
    rep_code_d  = REP_CLEAR;
    if (op_q == OP_SETUP) begin
      nxt.over_limit  = high_limit_q;
      nxt.under_limit = low_limit_q;
      nxt.high_mode   = high_en_q ? SIDE_ARMED : SIDE_MASKED;
      nxt.low_mode    = low_en_q ? SIDE_ARMED : SIDE_MASKED;
    end else if (over) begin
      if (cur.low_mode[1]) begin
        nxt.low_mode = SIDE_ARMED;
      end
      if (cur.high_mode == SIDE_FREE) begin
        nxt.high_mode = SIDE_TRIPPED;
        rep_valid_d   = 1'b1;
        rep_code_d    = REP_OVER;
      end else if (cur.high_mode == SIDE_ARMED) begin
        nxt.high_mode = SIDE_FREE;
      end
    end else if (under) begin
      if (cur.high_mode[1]) begin
        nxt.high_mode = SIDE_ARMED;
      end
      if (cur.low_mode == SIDE_FREE) begin
        nxt.low_mode = SIDE_TRIPPED;
        rep_valid_d  = 1'b1;
        rep_code_d   = REP_UNDER;
      end else if (cur.low_mode == SIDE_ARMED) begin
        nxt.low_mode = SIDE_FREE;
      end
    end else if (cur.high_mode[1] || cur.low_mode[1]) begin
      if (cur.high_mode == SIDE_FREE || cur.low_mode == SIDE_FREE) begin
        nxt.event_count = cur.event_count + COUNT_W'(1);
      end
      rep_valid_d = 1'b1;
      rep_code_d  = REP_CLEAR;
      if (cur.high_mode != SIDE_MASKED) begin
        nxt.high_mode = SIDE_ARMED;
      end
      if (cur.low_mode != SIDE_MASKED) begin
        nxt.low_mode = SIDE_ARMED;
      end
    end
  end

  always_comb begin
    busy_d      = busy_q;
    out_valid_d = out_valid_q;
    written_d   = written_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (finish) begin
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
      if (in_range) begin
        written_d[waddr] = 1'b1;
      end
    end
    if (accept) begin
      busy_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
      written_q   <= '0;
    end else begin
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
      written_q   <= written_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      ochan_q <= chan_q;
      if (in_range) begin
        rep_valid_q <= rep_valid_d;
        rep_code_q  <= rep_code_d;
        hs_q        <= nxt.high_mode;
        ls_q        <= nxt.low_mode;
        total_q     <= nxt.event_count;
      end else begin
        rep_valid_q <= 1'b0;
        rep_code_q  <= REP_CLEAR;
        hs_q        <= SIDE_MASKED;
        ls_q        <= SIDE_MASKED;
        total_q     <= '0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_channel_o  = ochan_q;
  assign report_valid_o = rep_valid_q;
  assign report_code_o  = rep_code_q;
  assign high_state_o   = hs_q;
  assign low_state_o    = ls_q;
  assign event_total_o  = 16'(total_q);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("accepted item did not block the input");

  a_finish_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> out_valid_o)
    else $error("finished item did not reach the output register");

  a_over_tripped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && report_valid_o && report_code_o == REP_OVER
      |-> high_state_o == SIDE_TRIPPED)
    else $error("over report without tripped high side");

  a_under_tripped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && report_valid_o && report_code_o == REP_UNDER
      |-> low_state_o == SIDE_TRIPPED)
    else $error("under report without tripped low side");

  a_quiet_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !report_valid_o |-> report_code_o == REP_CLEAR)
    else $error("report code set without a report");

endmodule

`default_nettype wire
